@@ sv/mhtq_pkg.sv @@
// Shared types, codes and constants of the min-heap timer queue.
`timescale 1ns / 1ps

package mhtq_pkg;

   localparam int HEAP_DEPTH_DEF = 32;

   localparam int FUNC_W = 2;
   localparam int ID_W   = 8;
   localparam int TIME_W = 32;
   localparam int KIND_W = 3;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

   // Response kinds
   localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DONE      = 3'd5;

   typedef struct packed {
      logic              live;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] expire;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ID_W-1:0]   timer_id;
      logic [TIME_W-1:0] expire_time;
      logic [TIME_W-1:0] now_time;
   } req_payload_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   fired_id;
      logic [TIME_W-1:0] fired_expire;
      logic              last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      POS_HOLD, POS_ZERO, POS_COUNT, POS_PARENT, POS_CHILD, POS_NEXT
   } pos_sel_type;

   typedef enum logic [2:0] {
      RD_ROOT, RD_PARENT, RD_LEFT, RD_RIGHT, RD_POS, RD_LAST
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NEW, WR_RD, WR_CLEAR, WR_CHILD, WR_ENT
   } wr_sel_type;

   typedef enum logic [2:0] {
      EMIT_FULL, EMIT_ADDED, EMIT_CXL, EMIT_FIRE, EMIT_DONE
   } emit_sel_type;

   typedef struct packed {
      logic         load_req;
      logic         count_inc;
      logic         count_dec;
      pos_sel_type  pos_sel;
      rd_sel_type   rd_sel;
      logic         wr_en;
      wr_sel_type   wr_sel;
      logic         ent_load;
      logic         left_load;
      logic         hit_set;
      logic         emit;
      emit_sel_type emit_sel;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic count_zero;
      logic pos_zero;
      logic parent_le;
      logic root_due;
      logic root_live;
      logic left_exists;
      logic right_exists;
      logic child_lt;
      logic match;
      logic scan_last;
      logic out_busy;
   } status_type;

endpackage

@@ sv/mhtq_ifs.sv @@
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps

interface mhtq_req_if;
   logic                        valid;
   logic                        ready;
   logic [mhtq_pkg::FUNC_W-1:0] func;
   logic [mhtq_pkg::ID_W-1:0]   timer_id;
   logic [mhtq_pkg::TIME_W-1:0] expire_time;
   logic [mhtq_pkg::TIME_W-1:0] now_time;

   modport source (output valid, func, timer_id, expire_time, now_time, input ready);
   modport sink (input valid, func, timer_id, expire_time, now_time, output ready);
endinterface

interface mhtq_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mhtq_pkg::KIND_W-1:0] kind;
   logic [mhtq_pkg::ID_W-1:0]   fired_id;
   logic [mhtq_pkg::TIME_W-1:0] fired_expire;
   logic                        last;

   modport source (output valid, kind, fired_id, fired_expire, last, input ready);
   modport sink (input valid, kind, fired_id, fired_expire, last, output ready);
endinterface

@@ sv/min_heap_timer_queue_top.sv @@
// Top level of the min-heap timer queue: controller, datapath and channel hookup.
`timescale 1ns / 1ps

// Binary min-heap of up to HEAP_DEPTH timers held in one single-port-read RAM. One
// request is handled at a time; every level of a heap walk costs RAM reads, one per
// cycle. Add: the new timer climbs from the end of the heap, at most log2 HEAP_DEPTH
// levels, moving each later parent down, and is written where its parent is not later.
// Cancel: every stored entry is scanned for the id. Tick: each due root is popped and
// fired if live, the last entry is moved to the root and sifted down, and the new root
// is looked at again; done is reported once the root is not due or the heap is empty.
// Every response also waits while the previous one sits untaken in the output register.
// A request is taken again as soon as the last response sits in the output register,
// even if it is not yet taken.
module min_heap_timer_queue_top #(
   parameter int HEAP_DEPTH = mhtq_pkg::HEAP_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   mhtq_req_if.sink   req_chan,
   mhtq_rsp_if.source rsp_chan
);

   mhtq_pkg::cmd_type         cmd;
   mhtq_pkg::status_type      status;
   mhtq_pkg::req_payload_type req_data;
   mhtq_pkg::rsp_payload_type rsp_data;
   logic                      req_ready;
   logic                      rsp_valid;

   assign req_data = '{func: req_chan.func, timer_id: req_chan.timer_id,
                       expire_time: req_chan.expire_time, now_time: req_chan.now_time};

   mhtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mhtq_dp #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.kind         = rsp_data.kind;
   assign rsp_chan.fired_id     = rsp_data.fired_id;
   assign rsp_chan.fired_expire = rsp_data.fired_expire;
   assign rsp_chan.last         = rsp_data.last;

endmodule

@@ sv/mhtq_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module mhtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/mhtq_dp.sv @@
// Datapath: heap storage, walk pointer, entry count, compares and response register.
`timescale 1ns / 1ps

module mhtq_dp #(
   parameter int HEAP_DEPTH = mhtq_pkg::HEAP_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mhtq_pkg::req_payload_type req_data,
   input  mhtq_pkg::cmd_type         cmd,
   output mhtq_pkg::status_type      status,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output mhtq_pkg::rsp_payload_type rsp_data
);

   localparam int IDX_W = $clog2(HEAP_DEPTH);
   localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
   localparam int CH_W  = IDX_W + 2;

   logic [CNT_W-1:0]            count_ff, count_in;
   logic [IDX_W-1:0]            pos_ff, pos_in;
   logic [mhtq_pkg::ID_W-1:0]   op_id_ff;
   logic [mhtq_pkg::TIME_W-1:0] op_exp_ff;
   logic [mhtq_pkg::TIME_W-1:0] op_now_ff;
   logic                        hit_ff;
   mhtq_pkg::entry_type         ent_ff;
   mhtq_pkg::entry_type         left_ff;
   logic                        rsp_valid_ff;
   mhtq_pkg::rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]             rd_addr;
   logic [mhtq_pkg::ENTRY_W-1:0] rd_raw;
   mhtq_pkg::entry_type          rd_ent;
   mhtq_pkg::entry_type          wr_ent;

   logic [CH_W-1:0]     left_idx, right_idx;
   logic [IDX_W-1:0]    parent_idx, child_idx;
   logic                take_right;
   mhtq_pkg::entry_type child_ent;

   mhtq_ram #(
      .WIDTH (mhtq_pkg::ENTRY_W),
      .DEPTH (HEAP_DEPTH)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (pos_ff),
      .wr_data (wr_ent),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_ent = mhtq_pkg::entry_type'(rd_raw);

   // Tree neighbors of the walk pointer
   assign left_idx   = CH_W'({pos_ff, 1'b1});
   assign right_idx  = left_idx + CH_W'(1);
   assign parent_idx = (pos_ff - IDX_W'(1)) >> 1;

   // In the compare step of a sift-down, rd_ent holds the right child if there is one
   assign take_right = status.right_exists && (rd_ent.expire < left_ff.expire);
   assign child_ent  = take_right ? rd_ent : left_ff;
   assign child_idx  = take_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];

   always_comb begin
      unique case (cmd.rd_sel)
         mhtq_pkg::RD_ROOT:   rd_addr = '0;
         mhtq_pkg::RD_PARENT: rd_addr = parent_idx;
         mhtq_pkg::RD_LEFT:   rd_addr = left_idx[IDX_W-1:0];
         mhtq_pkg::RD_RIGHT:  rd_addr = right_idx[IDX_W-1:0];
         mhtq_pkg::RD_POS:    rd_addr = pos_ff;
         mhtq_pkg::RD_LAST:   rd_addr = count_ff[IDX_W-1:0];
         default:             rd_addr = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.wr_sel)
         mhtq_pkg::WR_NEW:   wr_ent = '{live: 1'b1, id: op_id_ff, expire: op_exp_ff};
         mhtq_pkg::WR_RD:    wr_ent = rd_ent;
         mhtq_pkg::WR_CLEAR: wr_ent = '{live: 1'b0, id: rd_ent.id, expire: rd_ent.expire};
         mhtq_pkg::WR_CHILD: wr_ent = child_ent;
         mhtq_pkg::WR_ENT:   wr_ent = ent_ff;
         default:            wr_ent = ent_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.pos_sel)
         mhtq_pkg::POS_HOLD:   pos_in = pos_ff;
         mhtq_pkg::POS_ZERO:   pos_in = '0;
         mhtq_pkg::POS_COUNT:  pos_in = count_ff[IDX_W-1:0];
         mhtq_pkg::POS_PARENT: pos_in = parent_idx;
         mhtq_pkg::POS_CHILD:  pos_in = child_idx;
         mhtq_pkg::POS_NEXT:   pos_in = pos_ff + IDX_W'(1);
         default:              pos_in = pos_ff;
      endcase
   end

   always_comb begin
      priority if (cmd.count_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      unique case (cmd.emit_sel)
         mhtq_pkg::EMIT_FULL: begin
            rsp_data_in = '{kind: mhtq_pkg::KIND_FULL, fired_id: op_id_ff,
                            fired_expire: op_exp_ff, last: 1'b1};
         end
         mhtq_pkg::EMIT_ADDED: begin
            rsp_data_in = '{kind: mhtq_pkg::KIND_ADDED, fired_id: op_id_ff,
                            fired_expire: op_exp_ff, last: 1'b1};
         end
         mhtq_pkg::EMIT_CXL: begin
            rsp_data_in = '{kind: hit_ff ? mhtq_pkg::KIND_CANCELLED : mhtq_pkg::KIND_NOT_FOUND,
                            fired_id: op_id_ff, fired_expire: '0, last: 1'b1};
         end
         mhtq_pkg::EMIT_FIRE: begin
            rsp_data_in = '{kind: mhtq_pkg::KIND_FIRED, fired_id: rd_ent.id,
                            fired_expire: rd_ent.expire, last: 1'b0};
         end
         mhtq_pkg::EMIT_DONE: begin
            rsp_data_in = '{kind: mhtq_pkg::KIND_DONE, fired_id: '0,
                            fired_expire: '0, last: 1'b1};
         end
         default: rsp_data_in = rsp_data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.load_req) begin
            hit_ff <= 1'b0;
         end else if (cmd.hit_set) begin
            hit_ff <= 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.load_req) begin
         op_id_ff  <= req_data.timer_id;
         op_exp_ff <= req_data.expire_time;
         op_now_ff <= req_data.now_time;
      end
      if (cmd.ent_load) begin
         ent_ff <= rd_ent;
      end
      if (cmd.left_load) begin
         left_ff <= rd_ent;
      end
      if (cmd.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign status.full         = count_ff == CNT_W'(HEAP_DEPTH);
   assign status.count_zero   = count_ff == '0;
   assign status.pos_zero     = pos_ff == '0;
   assign status.parent_le    = rd_ent.expire <= op_exp_ff;
   assign status.root_due     = rd_ent.expire <= op_now_ff;
   assign status.root_live    = rd_ent.live;
   assign status.left_exists  = left_idx < CH_W'(count_ff);
   assign status.right_exists = right_idx < CH_W'(count_ff);
   assign status.child_lt     = child_ent.expire < ent_ff.expire;
   assign status.match        = rd_ent.live && (rd_ent.id == op_id_ff);
   assign status.scan_last    = (CNT_W'(pos_ff) + CNT_W'(1)) == count_ff;
   assign status.out_busy     = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(HEAP_DEPTH))
      else $error("entry count above heap depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid_ff && !rsp_ready))
      else $error("response register overwritten while stalled");

   a_inc_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.count_inc |-> count_ff < CNT_W'(HEAP_DEPTH))
      else $error("insert into a full heap");

   a_dec_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.count_dec |-> count_ff != '0)
      else $error("pop from an empty heap");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> CNT_W'(pos_ff) < count_ff)
      else $error("heap write beyond the stored entries");

endmodule

@@ sv/mhtq_ctrl.sv @@
// Controller: sequences add, cancel and tick transactions over the heap datapath.
`timescale 1ns / 1ps

module mhtq_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [mhtq_pkg::FUNC_W-1:0] req_func,
   output logic                        req_ready,
   input  mhtq_pkg::status_type        status,
   output mhtq_pkg::cmd_type           cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_ADD, S_ADD_CHK, S_ADD_CMP, S_ADD_DONE,
      S_CXL, S_CXL_RD, S_CXL_CHK, S_CXL_DONE,
      S_TICK, S_TICK_CHK, S_TICK_LAST, S_TICK_LD,
      S_SD_L, S_SD_R, S_SD_CMP, S_TICK_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.pos_sel   = mhtq_pkg::POS_HOLD;
      cmd.rd_sel    = mhtq_pkg::RD_ROOT;
      cmd.wr_sel    = mhtq_pkg::WR_ENT;
      cmd.emit_sel  = mhtq_pkg::EMIT_DONE;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               priority if (req_func == mhtq_pkg::FUNC_ADD) begin
                  state_in = S_ADD;
               end else if (req_func == mhtq_pkg::FUNC_CANCEL) begin
                  state_in = S_CXL;
               end else if (req_func == mhtq_pkg::FUNC_TICK) begin
                  state_in = S_TICK;
               end else begin
                  state_in = S_IDLE;    // unused code: drop
               end
            end
         end

         S_ADD: begin
            if (status.full) begin
               if (!status.out_busy) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = mhtq_pkg::EMIT_FULL;
                  state_in     = S_IDLE;
               end
            end else begin
               cmd.pos_sel   = mhtq_pkg::POS_COUNT;
               cmd.count_inc = 1'b1;
               state_in      = S_ADD_CHK;
            end
         end

         S_ADD_CHK: begin
            if (status.pos_zero) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = mhtq_pkg::WR_NEW;
               state_in   = S_ADD_DONE;
            end else begin
               cmd.rd_sel = mhtq_pkg::RD_PARENT;
               state_in   = S_ADD_CMP;
            end
         end

         S_ADD_CMP: begin
            cmd.wr_en = 1'b1;
            if (status.parent_le) begin
               cmd.wr_sel = mhtq_pkg::WR_NEW;
               state_in   = S_ADD_DONE;
            end else begin
               // move parent down and climb
               cmd.wr_sel  = mhtq_pkg::WR_RD;
               cmd.pos_sel = mhtq_pkg::POS_PARENT;
               state_in    = S_ADD_CHK;
            end
         end

         S_ADD_DONE: begin
            if (!status.out_busy) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = mhtq_pkg::EMIT_ADDED;
               state_in     = S_IDLE;
            end
         end

         S_CXL: begin
            cmd.pos_sel = mhtq_pkg::POS_ZERO;
            state_in    = status.count_zero ? S_CXL_DONE : S_CXL_RD;
         end

         S_CXL_RD: begin
            cmd.rd_sel = mhtq_pkg::RD_POS;
            state_in   = S_CXL_CHK;
         end

         S_CXL_CHK: begin
            if (status.match) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = mhtq_pkg::WR_CLEAR;
               cmd.hit_set = 1'b1;
            end
            if (status.scan_last) begin
               state_in = S_CXL_DONE;
            end else begin
               cmd.pos_sel = mhtq_pkg::POS_NEXT;
               state_in    = S_CXL_RD;
            end
         end

         S_CXL_DONE: begin
            if (!status.out_busy) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = mhtq_pkg::EMIT_CXL;
               state_in     = S_IDLE;
            end
         end

         S_TICK: begin
            cmd.rd_sel = mhtq_pkg::RD_ROOT;
            state_in   = status.count_zero ? S_TICK_DONE : S_TICK_CHK;
         end

         S_TICK_CHK: begin
            // keep addressing the root so its data holds during a stall
            cmd.rd_sel = mhtq_pkg::RD_ROOT;
            if (!status.root_due) begin
               state_in = S_TICK_DONE;
            end else if (!(status.root_live && status.out_busy)) begin
               cmd.emit      = status.root_live;
               cmd.emit_sel  = mhtq_pkg::EMIT_FIRE;
               cmd.count_dec = 1'b1;
               state_in      = S_TICK_LAST;
            end
         end

         S_TICK_LAST: begin
            if (status.count_zero) begin
               state_in = S_TICK;
            end else begin
               cmd.rd_sel  = mhtq_pkg::RD_LAST;
               cmd.pos_sel = mhtq_pkg::POS_ZERO;
               state_in    = S_TICK_LD;
            end
         end

         S_TICK_LD: begin
            cmd.ent_load = 1'b1;
            state_in     = S_SD_L;
         end

         S_SD_L: begin
            if (status.left_exists) begin
               cmd.rd_sel = mhtq_pkg::RD_LEFT;
               state_in   = S_SD_R;
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = mhtq_pkg::WR_ENT;
               state_in   = S_TICK;
            end
         end

         S_SD_R: begin
            cmd.left_load = 1'b1;
            cmd.rd_sel    = status.right_exists ? mhtq_pkg::RD_RIGHT : mhtq_pkg::RD_LEFT;
            state_in      = S_SD_CMP;
         end

         S_SD_CMP: begin
            cmd.wr_en = 1'b1;
            if (status.child_lt) begin
               cmd.wr_sel  = mhtq_pkg::WR_CHILD;
               cmd.pos_sel = mhtq_pkg::POS_CHILD;
               state_in    = S_SD_L;
            end else begin
               cmd.wr_sel = mhtq_pkg::WR_ENT;
               state_in   = S_TICK;
            end
         end

         S_TICK_DONE: begin
            if (!status.out_busy) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = mhtq_pkg::EMIT_DONE;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;

   a_one_emit_source: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !cmd.load_req && !cmd.count_inc)
      else $error("response issued while taking a request or inserting");

   a_no_rw_same_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> !(cmd.count_inc || cmd.count_dec))
      else $error("heap write while the entry count moves");

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> state_ff != S_TICK_CHK && state_ff != S_SD_CMP)
      else $error("request accepted in the middle of a heap walk");

endmodule

@@ sim/tb_min_heap_timer_queue_top.sv @@
// Testbench for the min-heap timer queue: directed and random traffic against a heap predictor.
`timescale 1ns / 1ps

module tb_min_heap_timer_queue_top;

   localparam int DEPTH   = mhtq_pkg::HEAP_DEPTH_DEF;
   localparam int ID_BITS = mhtq_pkg::ID_W;
   localparam logic [mhtq_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [mhtq_pkg::TIME_W-1:0] TIME_MAX = 32'hFFFF_FFFF;
   localparam int RANDOM_ITEMS = 400;
   localparam int QUIET_AFTER = 340;

   logic clock;
   logic reset;

   mhtq_req_if req_chan ();
   mhtq_rsp_if rsp_chan ();

   min_heap_timer_queue_top #(.HEAP_DEPTH(DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predicted heap contents
   logic [mhtq_pkg::TIME_W-1:0] slot_expire [DEPTH];
   logic [mhtq_pkg::ID_W-1:0]   slot_id     [DEPTH];
   logic                        slot_live   [DEPTH];
   int unsigned                 slot_count;

   mhtq_pkg::rsp_payload_type   awaited_rsp [$];
   mhtq_pkg::rsp_payload_type   want_rsp;
   int unsigned                 fault_count;
   bit                          quiet_phase;
   int unsigned                 random_sent;
   logic [mhtq_pkg::TIME_W-1:0] timeline;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic void post_rsp(input logic [mhtq_pkg::KIND_W-1:0] kind,
                                    input logic [mhtq_pkg::ID_W-1:0] id,
                                    input logic [mhtq_pkg::TIME_W-1:0] expire_t,
                                    input logic last);
      mhtq_pkg::rsp_payload_type r;
      r.kind         = kind;
      r.fired_id     = id;
      r.fired_expire = expire_t;
      r.last         = last;
      awaited_rsp.push_back(r);
   endfunction

   function automatic void sink_root();
      int unsigned                 pos;
      int unsigned                 child;
      logic [mhtq_pkg::TIME_W-1:0] e;
      logic [mhtq_pkg::ID_W-1:0]   id;
      logic                        lv;
      bit                          settled;
      pos     = 0;
      e       = slot_expire[0];
      id      = slot_id[0];
      lv      = slot_live[0];
      settled = 1'b0;
      while (!settled && pos * 2 + 1 < slot_count) begin
         child = pos * 2 + 1;
         // right child only when strictly earlier
         if (child + 1 < slot_count && slot_expire[child + 1] < slot_expire[child])
            child++;
         if (slot_expire[child] < e) begin
            slot_expire[pos] = slot_expire[child];
            slot_id[pos]     = slot_id[child];
            slot_live[pos]   = slot_live[child];
            pos = child;
         end else begin
            settled = 1'b1;
         end
      end
      slot_expire[pos] = e;
      slot_id[pos]     = id;
      slot_live[pos]   = lv;
   endfunction

   function automatic void heap_apply(input mhtq_pkg::req_payload_type rq);
      int unsigned pos;
      int unsigned parent;
      int unsigned fired;
      bit          hit;
      bit          stop_climb;
      unique case (rq.func)
         mhtq_pkg::FUNC_ADD: begin
            if (slot_count >= DEPTH) begin
               post_rsp(mhtq_pkg::KIND_FULL, rq.timer_id, rq.expire_time, 1'b1);
            end else begin
               pos = slot_count;
               slot_count++;
               stop_climb = 1'b0;
               // equal key stays under its parent
               while (!stop_climb && pos > 0) begin
                  parent = (pos - 1) / 2;
                  if (slot_expire[parent] <= rq.expire_time) begin
                     stop_climb = 1'b1;
                  end else begin
                     slot_expire[pos] = slot_expire[parent];
                     slot_id[pos]     = slot_id[parent];
                     slot_live[pos]   = slot_live[parent];
                     pos = parent;
                  end
               end
               slot_expire[pos] = rq.expire_time;
               slot_id[pos]     = rq.timer_id;
               slot_live[pos]   = 1'b1;
               post_rsp(mhtq_pkg::KIND_ADDED, rq.timer_id, rq.expire_time, 1'b1);
            end
         end
         mhtq_pkg::FUNC_CANCEL: begin
            hit = 1'b0;
            for (int unsigned i = 0; i < slot_count; i++) begin
               if (slot_id[i] == rq.timer_id && slot_live[i]) begin
                  slot_live[i] = 1'b0;
                  hit = 1'b1;
               end
            end
            post_rsp(hit ? mhtq_pkg::KIND_CANCELLED : mhtq_pkg::KIND_NOT_FOUND,
                     rq.timer_id, '0, 1'b1);
         end
         mhtq_pkg::FUNC_TICK: begin
            fired = 0;
            while (slot_count > 0 && slot_expire[0] <= rq.now_time) begin
               if (slot_live[0] && fired < DEPTH) begin
                  post_rsp(mhtq_pkg::KIND_FIRED, slot_id[0], slot_expire[0], 1'b0);
                  fired++;
               end
               slot_count--;
               slot_expire[0] = slot_expire[slot_count];
               slot_id[0]     = slot_id[slot_count];
               slot_live[0]   = slot_live[slot_count];
               if (slot_count > 0)
                  sink_root();
            end
            post_rsp(mhtq_pkg::KIND_DONE, '0, '0, 1'b1);
         end
         default: begin
         end
      endcase
   endfunction

   // Hold ready low in random bursts, with clear runs in between
   initial begin : rsp_ready_gen
      int unsigned stall_left;
      int unsigned run_left;
      stall_left = 0;
      run_left   = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (quiet_phase) begin
            rsp_chan.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (run_left > 0) begin
            rsp_chan.ready <= 1'b1;
            run_left--;
         end else if ($urandom_range(0, 1) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = $urandom_range(0, 17);
         end else begin
            rsp_chan.ready <= 1'b1;
            run_left = $urandom_range(0, 40);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (awaited_rsp.size() == 0) begin
            if (fault_count < 10)
               $display("%0t: unexpected response kind=%0d id=%0d expire=%0d last=%0d",
                        $realtime, rsp_chan.kind, rsp_chan.fired_id, rsp_chan.fired_expire,
                        rsp_chan.last);
            fault_count++;
         end else begin
            want_rsp = awaited_rsp.pop_front();
            if (rsp_chan.kind !== want_rsp.kind || rsp_chan.fired_id !== want_rsp.fired_id ||
                rsp_chan.fired_expire !== want_rsp.fired_expire ||
                rsp_chan.last !== want_rsp.last) begin
               if (fault_count < 10)
                  $display("%0t: mismatch expected kind=%0d id=%0d expire=%0d last=%0d,",
                           $realtime, want_rsp.kind, want_rsp.fired_id,
                           want_rsp.fired_expire, want_rsp.last,
                           " got kind=%0d id=%0d expire=%0d last=%0d",
                           rsp_chan.kind, rsp_chan.fired_id,
                           rsp_chan.fired_expire, rsp_chan.last);
               fault_count++;
            end
         end
      end
   end

   // Drive one request and wait until it is taken; valid stays high into the next call
   task automatic send_request(input logic [mhtq_pkg::FUNC_W-1:0] func,
                               input logic [mhtq_pkg::ID_W-1:0] id,
                               input logic [mhtq_pkg::TIME_W-1:0] expire_t,
                               input logic [mhtq_pkg::TIME_W-1:0] now_t);
      mhtq_pkg::req_payload_type rq;
      int unsigned               gap;
      rq.func        = func;
      rq.timer_id    = id;
      rq.expire_time = expire_t;
      rq.now_time    = now_t;
      @(negedge clock);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.func        <= func;
      req_chan.timer_id    <= id;
      req_chan.expire_time <= expire_t;
      req_chan.now_time    <= now_t;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      heap_apply(rq);
   endtask

   task automatic arm_timer(input logic [mhtq_pkg::ID_W-1:0] id,
                            input logic [mhtq_pkg::TIME_W-1:0] expire_t);
      send_request(mhtq_pkg::FUNC_ADD, id, expire_t, $urandom());
   endtask

   task automatic cancel_timer(input logic [mhtq_pkg::ID_W-1:0] id);
      send_request(mhtq_pkg::FUNC_CANCEL, id, $urandom(), $urandom());
   endtask

   task automatic tick_at(input logic [mhtq_pkg::TIME_W-1:0] now_t);
      send_request(mhtq_pkg::FUNC_TICK, ID_BITS'($urandom()), $urandom(), now_t);
   endtask

   task automatic test_add_and_cancel();
      tick_at('0);
      arm_timer(8'h00, TIME_MAX);
      arm_timer(8'hFF, '0);
      arm_timer(8'hA5, 32'd100);
      arm_timer(8'h5A, 32'd100);
      arm_timer(8'h07, 32'd100);
      cancel_timer(8'h5A);
      // second cancel of the same id finds nothing live
      cancel_timer(8'h5A);
      cancel_timer(8'h33);
   endtask

   task automatic test_unused_func();
      send_request(FUNC_UNUSED, 8'hFF, TIME_MAX, TIME_MAX);
      send_request(FUNC_UNUSED, 8'h00, '0, '0);
   endtask

   task automatic test_tick_order();
      tick_at(32'd99);
      arm_timer(8'h09, 32'd50);
      arm_timer(8'h09, 32'd40);
      cancel_timer(8'h09);
      tick_at(32'd100);
      arm_timer(8'h01, TIME_MAX);
      cancel_timer(8'h00);
      tick_at(TIME_MAX);
      tick_at(TIME_MAX);
   endtask

   task automatic random_add();
      logic [mhtq_pkg::ID_W-1:0]   id;
      logic [mhtq_pkg::TIME_W-1:0] expire_t;
      id = ($urandom_range(0, 3) == 0) ? ID_BITS'($urandom_range(0, 255))
                                       : ID_BITS'($urandom_range(0, 15));
      if ($urandom_range(0, 15) == 0)
         expire_t = $urandom();
      else
         expire_t = timeline + $urandom_range(0, 20) * 10;
      arm_timer(id, expire_t);
      random_sent++;
   endtask

   // Fill the heap, push a few refused adds, then tick to drain the timers that are due
   task automatic fill_and_drain();
      while (slot_count < DEPTH && random_sent < RANDOM_ITEMS)
         random_add();
      repeat ($urandom_range(1, 3)) random_add();
      if ($urandom_range(0, 1) == 0)
         tick_at(TIME_MAX);
      else
         tick_at(timeline + 300);
      random_sent++;
   endtask

   task automatic test_random_traffic();
      int unsigned pick;
      timeline    = 32'd1000;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         quiet_phase = (random_sent >= QUIET_AFTER);
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            fill_and_drain();
         end else if (pick < 8) begin
            send_request(FUNC_UNUSED, ID_BITS'($urandom()), $urandom(), $urandom());
         end else if (pick < 52) begin
            random_add();
         end else if (pick < 68) begin
            cancel_timer(($urandom_range(0, 4) == 0) ? ID_BITS'($urandom_range(0, 255))
                                                     : ID_BITS'($urandom_range(0, 15)));
            random_sent++;
         end else begin
            timeline = timeline + $urandom_range(0, 120);
            tick_at(($urandom_range(0, 19) == 0) ? $urandom() : timeline);
            random_sent++;
         end
      end
      quiet_phase = 1'b1;
   endtask

   initial begin
      reset                = 1'b1;
      quiet_phase          = 1'b0;
      fault_count          = 0;
      slot_count           = 0;
      req_chan.valid       = 1'b0;
      req_chan.func        = mhtq_pkg::FUNC_ADD;
      req_chan.timer_id    = '0;
      req_chan.expire_time = '0;
      req_chan.now_time    = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_add_and_cancel();
      test_unused_func();
      test_tick_order();
      test_random_traffic();

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fault_count == 0 && awaited_rsp.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
